// File: rtl/crs_pkg.sv
//------------------------------------------------------------------------------
// crs_pkg
// Shared constants and types for the carousel rotation selector.
//------------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

	localparam int MAX_SLOTS = 8;
	localparam int SLOT_W    = 3;                  // shown_slot width
	localparam int CNT_W     = 4;                  // slot_count width
	localparam int MASK_W    = 8;                  // per-slot masks
	localparam int POS_W     = CNT_W + 1;          // walk position before reduction
	localparam int TS_W      = 32;

	localparam logic [TS_W-1:0] LIVE_INTERVAL_MS = TS_W'(1000);
	localparam logic [CNT_W-1:0] MAX_SLOTS_C     = CNT_W'(MAX_SLOTS);

	// register reset values
	localparam logic [CNT_W-1:0]  SLOT_COUNT_RST = '0;
	localparam logic [MASK_W-1:0] ENABLED_RST    = 8'hFF;
	localparam logic [MASK_W-1:0] NO_SLOT        = 8'hFF;
	localparam logic [TS_W-1:0]   DWELL_RST      = TS_W'(10000);

	// register indexes
	localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
	localparam logic [1:0] REG_ENABLED    = 2'd1;
	localparam logic [1:0] REG_PRIORITY   = 2'd2;
	localparam logic [1:0] REG_DWELL      = 2'd3;

	// item modes
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_GESTURE = 2'd1;
	localparam logic [1:0] MODE_START   = 2'd2;

	// gestures
	localparam logic [2:0] G_NONE        = 3'd0;
	localparam logic [2:0] G_SWIPE_LEFT  = 3'd1;
	localparam logic [2:0] G_SWIPE_RIGHT = 3'd2;
	localparam logic [2:0] G_DOUBLE_TAP  = 3'd3;
	localparam logic [2:0] G_TAP         = 3'd4;

	typedef struct packed {
		logic              start;
		logic              backward;
		logic [SLOT_W-1:0] from;
	} walk_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] target;
	} walk_rsp_t;

endpackage

`default_nettype wire

// File: rtl/crs_walker.sv
//------------------------------------------------------------------------------
// crs_walker
// Circular search for the next usable slot, one candidate per cycle, after
// reducing the start position modulo slot_count by repeated subtraction.
//------------------------------------------------------------------------------
`default_nettype none

module crs_walker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  crs_pkg::walk_req_t           req,
	input  wire  [crs_pkg::CNT_W-1:0]    slot_count,
	input  wire  [crs_pkg::MASK_W-1:0]   enabled_mask,
	input  wire  [crs_pkg::MASK_W-1:0]   priority_slot,
	input  wire  [crs_pkg::MASK_W-1:0]   has_data_mask,
	output crs_pkg::walk_rsp_t           rsp
);
	import crs_pkg::*;

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_MOD  = 2'd1;
	localparam logic [1:0] W_SCAN = 2'd2;

	logic [1:0]        state_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  step_q;
	logic [SLOT_W-1:0] from_q;
	logic              back_q;
	logic              done_q;
	logic [SLOT_W-1:0] target_q;

	logic [POS_W-1:0]  cnt_ext;
	logic [SLOT_W-1:0] cand;
	logic [SLOT_W-1:0] last;
	logic              usable;

	assign cnt_ext = {1'b0, slot_count};
	assign cand    = pos_q[SLOT_W-1:0];
	assign last    = SLOT_W'(slot_count - CNT_W'(1));
	// candidate is always below slot_count here, so only enable/priority/data matter
	assign usable  = (enabled_mask[cand] || (priority_slot == MASK_W'(cand)))
	                 && has_data_mask[cand];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == W_SCAN) && (usable || step_q == slot_count);
			case (state_q)
				W_IDLE: begin
					if (req.start) begin
						state_q <= W_MOD;
					end
				end
				W_MOD: begin
					if (pos_q < cnt_ext) begin
						state_q <= W_SCAN;
					end
				end
				W_SCAN: begin
					if (usable || step_q == slot_count) begin
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				from_q <= req.from;
				back_q <= req.backward;
				step_q <= CNT_W'(1);
				if (req.backward) begin
					pos_q <= POS_W'({2'b0, req.from} + {cnt_ext[POS_W-2:0], 1'b0} - POS_W'(1));
				end else begin
					pos_q <= POS_W'({2'b0, req.from} + POS_W'(1));
				end
			end
			W_MOD: begin
				if (pos_q >= cnt_ext) begin
					pos_q <= pos_q - cnt_ext;
				end
			end
			W_SCAN: begin
				if (usable) begin
					target_q <= cand;
				end else if (step_q == slot_count) begin
					target_q <= from_q;
				end else begin
					step_q <= step_q + CNT_W'(1);
					if (back_q) begin
						pos_q <= (cand == '0) ? POS_W'(last) : pos_q - POS_W'(1);
					end else begin
						pos_q <= (cand == last) ? '0 : pos_q + POS_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.target = target_q;

endmodule

`default_nettype wire

// File: rtl/carousel_rotation_selector.sv
//------------------------------------------------------------------------------
// carousel_rotation_selector
// Chooses the display slot to show from ticks, gestures and start items.
//------------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) carries one item: mode, gesture, the
//    per-slot has-data mask, consume/redraw/low-power flags and now_ms.
//  - Output channel (out_valid/out_stall) returns exactly one result item per
//    input item, in order. The result sits in an output register and holds
//    while out_stall is high.
//  - Items without a slot walk pass through the execute and done steps to
//    the output register. A walk over the slots goes through a shared
//    walker: modulo reduction of the start position, then a scan of at most
//    slot_count candidate slots, then a registered handoff of the result.
//    in_stall is high from acceptance until the result is loaded, so items
//    are taken one at a time; a new item may be taken while a finished
//    result waits.
//  - A finished item waits in its last step while the output register is full
//    and stalled.
//  - Registers must be written via the APB port only while idle; not enforced.
//  - Reset clears the rotation state and loads the register reset values.
//------------------------------------------------------------------------------
`default_nettype none

module carousel_rotation_selector (
	input  wire        clk,
	input  wire        arst_n,
	// APB register port
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [3:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	// input items
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [1:0]  mode,
	input  wire [2:0]  gesture,
	input  wire [7:0]  has_data_mask,
	input  wire        slot_consumed,
	input  wire        needs_redraw,
	input  wire        low_power,
	input  wire [31:0] now_ms,
	// result items
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] shown_slot,
	output logic       slot_switched,
	output logic       content_redraw,
	output logic       footer_redraw,
	output logic       held,
	output logic       live
);
	import crs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// configuration
	logic [CNT_W-1:0]  slot_count_q;
	logic [MASK_W-1:0] enabled_q;
	logic [MASK_W-1:0] priority_q;
	logic [TS_W-1:0]   dwell_q;

	// rotation state
	logic [SLOT_W-1:0] cur_q;
	logic              hold_q;
	logic              pwa_q;
	logic [TS_W-1:0]   since_q;
	logic [TS_W-1:0]   refresh_q;

	// latched item
	logic [1:0]        mode_q;
	logic [2:0]        gesture_q;
	logic [MASK_W-1:0] hd_q;
	logic              consumed_q;
	logic              needs_q;
	logic              lowp_q;
	logic [TS_W-1:0]   now_q;

	// result under construction
	logic              sw_q, ct_q, ft_q, live_q, wstart_q;

	logic [1:0]        state_q;
	logic              out_valid_q;

	walk_req_t         wreq;
	walk_rsp_t         wrsp;

	// ---------------- APB ----------------
	logic       wr_en;
	logic [1:0] reg_idx;
	logic [CNT_W-1:0] wr_cnt;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign wr_cnt  = (pwdata[CNT_W-1:0] > MAX_SLOTS_C) ? MAX_SLOTS_C : pwdata[CNT_W-1:0];

	always_comb begin
		case (reg_idx)
			REG_SLOT_COUNT: prdata = {28'b0, slot_count_q};
			REG_ENABLED:    prdata = {24'b0, enabled_q};
			REG_PRIORITY:   prdata = {24'b0, priority_q};
			REG_DWELL:      prdata = dwell_q;
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			enabled_q    <= ENABLED_RST;
			priority_q   <= NO_SLOT;
			dwell_q      <= DWELL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SLOT_COUNT: slot_count_q <= wr_cnt;
				REG_ENABLED: begin
					if (pwdata[MASK_W-1:0] != '0) begin
						enabled_q <= pwdata[MASK_W-1:0];
					end
				end
				REG_PRIORITY: priority_q <= pwdata[MASK_W-1:0];
				REG_DWELL:    dwell_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// ---------------- item decode ----------------
	logic [SLOT_W-1:0] prio_slot;
	logic              pa;
	logic              active;

	assign prio_slot = priority_q[SLOT_W-1:0];
	assign pa        = (priority_q < {4'b0, slot_count_q}) && hd_q[prio_slot];
	assign active    = (slot_count_q != '0);

	// tick evaluation
	logic              t_switch;     // priority newly active and not held
	logic              t_lost;       // priority went inactive
	logic              t_live;
	logic [TS_W-1:0]   t_since;
	logic              t_expired;

	assign t_switch  = pa && !pwa_q && !hold_q;
	assign t_lost    = !pa && pwa_q;
	assign t_live    = !lowp_q && needs_q && ((now_q - refresh_q) > LIVE_INTERVAL_MS);
	assign t_since   = t_lost ? now_q : since_q;
	assign t_expired = !hold_q && ((now_q - t_since) >= dwell_q);

	// result flags of the execute step
	logic              e_sw, e_ct, e_ft;

	always_comb begin
		e_sw = 1'b0;
		e_ct = 1'b0;
		e_ft = 1'b0;
		if (active) begin
			case (mode_q)
				MODE_TICK: begin
					if (t_switch) begin
						e_sw = 1'b1;
						e_ct = 1'b1;
					end else begin
						e_ft = (pa && !pwa_q) || t_lost;
						e_ct = t_live || (t_expired && pa && cur_q != prio_slot);
						e_sw = t_expired && pa && cur_q != prio_slot;
					end
				end
				MODE_GESTURE: begin
					if (gesture_q != G_NONE && gesture_q <= G_TAP) begin
						if (consumed_q) begin
							e_ct = 1'b1;
						end else if (gesture_q == G_DOUBLE_TAP) begin
							e_ft = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		wreq.from     = (mode_q == MODE_START) ? '0 : cur_q;
		wreq.backward = (mode_q == MODE_GESTURE) && (gesture_q == G_SWIPE_RIGHT);
		wreq.start    = 1'b0;
		if (state_q == S_EXEC && active) begin
			case (mode_q)
				MODE_TICK:
					wreq.start = !t_switch && t_expired && !pa;
				MODE_GESTURE:
					wreq.start = !consumed_q &&
					             (gesture_q == G_SWIPE_LEFT || gesture_q == G_SWIPE_RIGHT);
				MODE_START:
					wreq.start = 1'b1;
				default:
					wreq.start = 1'b0;
			endcase
		end
	end

	crs_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (wreq),
		.slot_count    (slot_count_q),
		.enabled_mask  (enabled_q),
		.priority_slot (priority_q),
		.has_data_mask (hd_q),
		.rsp           (wrsp)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			hold_q      <= 1'b0;
			pwa_q       <= 1'b0;
			since_q     <= '0;
			refresh_q   <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= wreq.start ? S_WALK : S_DONE;
					if (active) begin
						case (mode_q)
							MODE_TICK: begin
								if (pa && !pwa_q) begin
									pwa_q <= 1'b1;
								end else if (t_lost) begin
									pwa_q <= 1'b0;
								end
								if (t_switch) begin
									cur_q   <= prio_slot;
									since_q <= now_q;
								end else begin
									if (t_live) begin
										refresh_q <= now_q;
									end
									if (t_expired && pa) begin
										cur_q   <= prio_slot;
										since_q <= now_q;
									end else begin
										since_q <= t_since;
									end
								end
							end
							MODE_GESTURE: begin
								if (consumed_q) begin
									if (gesture_q != G_NONE && gesture_q <= G_TAP) begin
										since_q <= now_q;
									end
								end else if (gesture_q == G_DOUBLE_TAP) begin
									hold_q  <= !hold_q;
									since_q <= now_q;
								end
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (wrsp.done) begin
						state_q <= S_DONE;
						cur_q   <= wrsp.target;
						since_q <= now_q;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: latched item, result flags and output register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_q     <= mode;
					gesture_q  <= gesture;
					hd_q       <= has_data_mask;
					consumed_q <= slot_consumed;
					needs_q    <= needs_redraw;
					lowp_q     <= low_power;
					now_q      <= now_ms;
				end
			end
			S_EXEC: begin
				sw_q     <= e_sw;
				ct_q     <= e_ct;
				ft_q     <= e_ft;
				live_q   <= pa;
				wstart_q <= (mode_q == MODE_START);
			end
			S_WALK: begin
				if (wrsp.done) begin
					ct_q <= 1'b1;
					// a start always reshows; a step only when the slot changes
					sw_q <= wstart_q || (wrsp.target != cur_q);
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					shown_slot     <= cur_q;
					slot_switched  <= sw_q;
					content_redraw <= ct_q;
					footer_redraw  <= ft_q;
					held           <= hold_q;
					live           <= live_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/crs_checker.sv
//------------------------------------------------------------------------------
// crs_checker
// Port-level checks on the carousel rotation selector, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module crs_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire [2:0] shown_slot,
	input wire       slot_switched,
	input wire       content_redraw,
	input wire       held
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(shown_slot) && $stable(held))
		else $error("result changed while stalled");

	// one item at a time: busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// a reshown slot always redraws its content
	a_switch_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot_switched |-> content_redraw)
		else $error("slot switch without content redraw");

	// no result right after an idle input with nothing pending
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_stall && !in_valid |=> !out_valid)
		else $error("result without an item");

endmodule

bind carousel_rotation_selector crs_checker u_crs_checker (.*);

`default_nettype wire
